// ===== sv/ascii_gas_frame_checker_unit_defines.svh =====
// Assertion macros used by the frame checker's port-level assertion module.
`ifndef ASCII_GAS_FRAME_CHECKER_UNIT_DEFINES_SVH
`define ASCII_GAS_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AGFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AGFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/agfc_pkg.sv =====
// Types, constants and helper functions for the ASCII gas frame checker.
package agfc_pkg;

    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DIG_LO = 8'd48;
    localparam logic [7:0] CH_DIG_HI = 8'd57;
    localparam logic [7:0] CH_HEX_LO = 8'd65;
    localparam logic [7:0] CH_HEX_HI = 8'd70;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

    // Frames shorter than 13 bytes are short: the end byte sits below position 12.
    localparam logic [3:0] POS_LAST_CHECK = 4'd12;
    localparam logic [3:0] POS_SUM_END    = 4'd10;
    localparam logic [3:0] POS_MAX        = 4'd15;

    localparam logic [3:0] POS_HUNDREDS  = 4'd0;
    localparam logic [3:0] POS_POINT     = 4'd1;
    localparam logic [3:0] POS_TENS      = 4'd2;
    localparam logic [3:0] POS_UNITS     = 4'd3;
    localparam logic [3:0] POS_CHECK_HI  = 4'd11;
    localparam logic [3:0] POS_CHECK_LO  = 4'd12;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_NO_POINT = 3'd2,
        ST_BLANK    = 3'd3,
        ST_SHORT    = 3'd4
    } status_t;

    // Frame contents as they stand once the end beat is folded in.
    typedef struct packed {
        logic       short_frame;
        logic [7:0] sum;
        logic [7:0] hundreds;
        logic [7:0] point;
        logic [7:0] tens;
        logic [7:0] units;
        logic [7:0] check_hi;
        logic [7:0] check_lo;
    } frame_snap_t;

    // Uppercase hex character to {valid, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
            v = c - CH_DIG_LO;
            return {1'b1, v[3:0]};
        end
        if (c >= CH_HEX_LO && c <= CH_HEX_HI) begin
            v = c - HEX_ALPHA_OFS;
            return {1'b1, v[3:0]};
        end
        return {1'b0, v[3:0]};
    endfunction

endpackage

// ===== sv/agfc_byte_if.sv =====
// Handshake channel carrying one received frame byte per beat.
interface agfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, rx_byte, frame_end, input ready);
    modport sink (input valid, rx_byte, frame_end, output ready);
endinterface

// ===== sv/agfc_result_if.sv =====
// Handshake channel carrying one decoded frame result per beat.
interface agfc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] concentration;
    logic [2:0]  status;

    modport source (output valid, concentration, status, input ready);
    modport sink (input valid, concentration, status, output ready);
endinterface

// ===== sv/ascii_gas_frame_checker_unit.sv =====
// The end beat is registered in the input register, its result in the result register.
// One byte beat per cycle unless the result side stalls; check logic feeds the result register.
// The result register frees the input side in the same cycle the sink takes its beat.
// Reset (rst_n low, asynchronous) clears the byte position, sum, captures and all valid flags.
module ascii_gas_frame_checker_unit
    import agfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    agfc_byte_if.sink    byte_ch,
    agfc_result_if.source result_ch
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_reg;
    logic        out_valid_reg;
    logic [15:0] out_conc_reg;
    logic [2:0]  out_status_reg;

    logic        s2_free;
    logic        advance;
    logic        take_in;
    frame_snap_t snap;
    logic [15:0] chk_conc;
    status_t     chk_status;

    assign s2_free = !out_valid_reg || result_ch.ready;
    assign advance = s1_valid_reg && s2_free;
    assign byte_ch.ready = !s1_valid_reg || s2_free;
    assign take_in = byte_ch.valid && byte_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_ch.ready)
            s1_valid_reg <= byte_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg <= byte_ch.rx_byte;
            s1_end_reg  <= byte_ch.frame_end;
        end
    end

    agfc_frame_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rx_byte   (s1_byte_reg),
        .frame_end (s1_end_reg),
        .snap      (snap)
    );

    agfc_frame_check u_check (
        .snap          (snap),
        .concentration (chk_conc),
        .status        (chk_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_free)
            out_valid_reg <= advance && s1_end_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_end_reg)
        begin
            out_conc_reg   <= chk_conc;
            out_status_reg <= chk_status;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.concentration = out_conc_reg;
    assign result_ch.status        = out_status_reg;

endmodule

// ===== sv/agfc_frame_track.sv =====
// Byte position, running sum and field captures for the frame in progress.
module agfc_frame_track
    import agfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output frame_snap_t snap
);

    logic [3:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] hund_reg, hund_next;
    logic [7:0] point_reg, point_next;
    logic [7:0] tens_reg, tens_next;
    logic [7:0] units_reg, units_next;
    logic [7:0] chi_reg, chi_next;
    logic [7:0] clo_reg, clo_next;

    // Values with the current beat applied
    always_comb
    begin
        sum_next   = (pos_reg < POS_SUM_END) ? 8'(sum_reg + rx_byte) : sum_reg;
        hund_next  = (pos_reg == POS_HUNDREDS) ? rx_byte : hund_reg;
        point_next = (pos_reg == POS_POINT)    ? rx_byte : point_reg;
        tens_next  = (pos_reg == POS_TENS)     ? rx_byte : tens_reg;
        units_next = (pos_reg == POS_UNITS)    ? rx_byte : units_reg;
        chi_next   = (pos_reg == POS_CHECK_HI) ? rx_byte : chi_reg;
        clo_next   = (pos_reg == POS_CHECK_LO) ? rx_byte : clo_reg;
        pos_next   = (pos_reg == POS_MAX) ? pos_reg : 4'(pos_reg + 4'd1);
    end

    always_comb
    begin
        snap.short_frame = (pos_reg < POS_LAST_CHECK);
        snap.sum         = sum_next;
        snap.hundreds    = hund_next;
        snap.point       = point_next;
        snap.tens        = tens_next;
        snap.units       = units_next;
        snap.check_hi    = chi_next;
        snap.check_lo    = clo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            hund_reg  <= '0;
            point_reg <= '0;
            tens_reg  <= '0;
            units_reg <= '0;
            chi_reg   <= '0;
            clo_reg   <= '0;
        end
        else if (advance)
        begin
            if (frame_end)
            begin
                pos_reg   <= '0;
                sum_reg   <= '0;
                hund_reg  <= '0;
                point_reg <= '0;
                tens_reg  <= '0;
                units_reg <= '0;
                chi_reg   <= '0;
                clo_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                hund_reg  <= hund_next;
                point_reg <= point_next;
                tens_reg  <= tens_next;
                units_reg <= units_next;
                chi_reg   <= chi_next;
                clo_reg   <= clo_next;
            end
        end
    end

endmodule

// ===== sv/agfc_frame_check.sv =====
// End-of-frame checks and concentration decode.
module agfc_frame_check
    import agfc_pkg::*;
(
    input  frame_snap_t snap,
    output logic [15:0] concentration,
    output status_t     status
);

    logic [4:0]  hi_dec;
    logic [4:0]  lo_dec;
    logic [7:0]  expect_sum;
    logic [15:0] d_hund;
    logic [15:0] d_tens;
    logic [15:0] d_units;
    logic [15:0] value;

    always_comb
    begin
        hi_dec     = hex_decode(snap.check_hi);
        lo_dec     = hex_decode(snap.check_lo);
        expect_sum = 8'(8'd0 - snap.sum);
        // Digits are not range checked; each wraps modulo 2^16
        d_hund  = 16'({8'h00, snap.hundreds} - {8'h00, CH_ZERO});
        d_tens  = 16'({8'h00, snap.tens} - {8'h00, CH_ZERO});
        d_units = 16'({8'h00, snap.units} - {8'h00, CH_ZERO});
        value   = 16'(16'(d_hund * 16'd100) + 16'(d_tens * 16'd10) + d_units);
    end

    always_comb
    begin
        concentration = '0;
        if (snap.short_frame)
            status = ST_SHORT;
        else if (!hi_dec[4] || !lo_dec[4] || {hi_dec[3:0], lo_dec[3:0]} != expect_sum)
            status = ST_CHECKSUM;
        else if (snap.point != CH_POINT)
            status = ST_NO_POINT;
        else if (snap.hundreds == CH_SPACE || snap.tens == CH_SPACE
                 || snap.units == CH_SPACE)
            status = ST_BLANK;
        else
        begin
            status        = ST_OK;
            concentration = value;
        end
    end

endmodule

// ===== sv/agfc_checker.sv =====
// Port-level assertions for the frame checker, bound to the top level.
`include "ascii_gas_frame_checker_unit_defines.svh"

module agfc_checker
    import agfc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] concentration,
    input logic [2:0]  status
);

    `AGFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
    `AGFC_ASSERT_NOW(a_reject_zero, out_valid && status != ST_OK, concentration == 16'd0, "rejected frame with nonzero concentration")
    `AGFC_ASSERT_NOW(a_status_range, out_valid, status <= ST_SHORT, "status code out of range")
    `AGFC_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input stalled with empty result register")

endmodule

bind ascii_gas_frame_checker_unit agfc_checker u_agfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (byte_ch.ready),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .concentration (result_ch.concentration),
    .status        (result_ch.status)
);

// ===== bench/ascii_gas_frame_checker_unit_tb.sv =====
// Self-checking bench for the ASCII gas frame checker: frames in, predicted readings checked.
`timescale 1ns / 1ps

module ascii_gas_frame_checker_unit_tb;
    import agfc_pkg::*;

    typedef struct {
        logic [15:0] concentration;
        status_t     status;
    } reading_t;

    logic clk;
    logic rst_n;

    agfc_byte_if   byte_ch ();
    agfc_result_if result_ch ();

    ascii_gas_frame_checker_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    // Predictor copy of the frame state
    logic [3:0] pos_q;
    logic [7:0] sum_q;
    logic [7:0] hund_q;
    logic [7:0] point_q;
    logic [7:0] tens_q;
    logic [7:0] units_q;
    logic [7:0] chk_hi_q;
    logic [7:0] chk_lo_q;

    reading_t   readings_due[$];
    logic [7:0] frame_bytes[$];
    int         error_count = 0;
    int         bytes_sent = 0;
    int         src_max_gap = 17;
    int         snk_max_stall = 17;

    always #5 clk = ~clk;

    function automatic void clear_frame();
        pos_q = '0;
        sum_q = '0;
        hund_q = '0;
        point_q = '0;
        tens_q = '0;
        units_q = '0;
        chk_hi_q = '0;
        chk_lo_q = '0;
    endfunction

    // Uppercase hex digit value, -1 for anything else
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 48;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 55;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return CH_HEX_LO + 8'(n) - 8'd10;
    endfunction

    // Folds one accepted byte into the frame; returns 1 with the reading on frame end.
    function automatic bit fold_rx_byte(input logic [7:0] b, input logic last,
                                        output reading_t r);
        int         frame_len;
        int         hi;
        int         lo;
        logic [7:0] want;

        r.concentration = '0;
        r.status = ST_OK;
        if (pos_q < POS_SUM_END)
            sum_q = sum_q + b;
        case (pos_q)
            POS_HUNDREDS: hund_q = b;
            POS_POINT:    point_q = b;
            POS_TENS:     tens_q = b;
            POS_UNITS:    units_q = b;
            POS_CHECK_HI: chk_hi_q = b;
            POS_CHECK_LO: chk_lo_q = b;
            default: ;
        endcase
        frame_len = int'(pos_q) + 1;
        if (pos_q != POS_MAX)
            pos_q = pos_q + 4'd1;
        if (!last)
            return 0;

        if (frame_len <= int'(POS_LAST_CHECK))
            r.status = ST_SHORT;
        else
        begin
            hi = hex_nibble(chk_hi_q);
            lo = hex_nibble(chk_lo_q);
            want = 8'd0 - sum_q;
            if (hi < 0 || lo < 0 || hi * 16 + lo != int'(want))
                r.status = ST_CHECKSUM;
            else if (point_q != CH_POINT)
                r.status = ST_NO_POINT;
            else if (hund_q == CH_SPACE || tens_q == CH_SPACE || units_q == CH_SPACE)
                r.status = ST_BLANK;
            else
                r.concentration = (16'(hund_q) - 16'(CH_ZERO)) * 16'd100
                                + (16'(tens_q) - 16'(CH_ZERO)) * 16'd10
                                + (16'(units_q) - 16'(CH_ZERO));
        end
        clear_frame();
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns  %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    function automatic int draw_wait(input int max_wait);
        if (max_wait == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, max_wait);
    endfunction

    // Beat monitor: predicts on input beats, checks output beats
    always @(posedge clk)
    begin
        reading_t r;
        reading_t due;

        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (fold_rx_byte(byte_ch.rx_byte, byte_ch.frame_end, r))
                    readings_due.push_back(r);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (readings_due.size() == 0)
                    report_mismatch("result beat with nothing due", -1,
                                    int'(result_ch.concentration));
                else
                begin
                    due = readings_due.pop_front();
                    if (result_ch.concentration !== due.concentration)
                        report_mismatch("concentration", int'(due.concentration),
                                        int'(result_ch.concentration));
                    if (result_ch.status !== due.status)
                        report_mismatch("status", int'(due.status), int'(result_ch.status));
                end
            end
        end
    end

    // Result sink with random stalls
    initial
    begin
        int k;

        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            k = draw_wait(snk_max_stall);
            @(negedge clk);
            if (k > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (k) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    task automatic send_rx_byte(input logic [7:0] b, input logic last);
        int gap;

        gap = draw_wait(src_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid = 1'b1;
        byte_ch.rx_byte = b;
        byte_ch.frame_end = last;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_rx_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Random filler, given head bytes, correct check characters, then cut to len
    function automatic void build_frame(input logic [7:0] h, input logic [7:0] p,
                                        input logic [7:0] t, input logic [7:0] u,
                                        input int len);
        logic [7:0] sum;
        logic [7:0] want;

        frame_bytes.delete();
        for (int i = 0; i < ((len > 13) ? len : 13); i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes[0] = h;
        frame_bytes[1] = p;
        frame_bytes[2] = t;
        frame_bytes[3] = u;
        sum = '0;
        for (int i = 0; i < 10; i++)
            sum = sum + frame_bytes[i];
        want = 8'd0 - sum;
        frame_bytes[11] = hex_char(want[7:4]);
        frame_bytes[12] = hex_char(want[3:0]);
        while (frame_bytes.size() > len)
            void'(frame_bytes.pop_back());
    endfunction

    task automatic test_short_frames();
        build_frame(8'hFF, CH_POINT, "1", "2", 1);
        send_frame();
        build_frame("1", CH_POINT, "2", "3", 12);
        send_frame();
    endtask

    task automatic test_good_frames();
        build_frame("1", CH_POINT, "2", "3", 13);
        send_frame();
        // long frame: position saturates, trailing bytes ignored
        build_frame("9", CH_POINT, "9", "9", 24);
        send_frame();
    endtask

    task automatic test_checksum_errors();
        logic [7:0] bad_hex[5];

        bad_hex = '{8'h61, 8'h47, 8'h3A, 8'h40, 8'h2F};
        build_frame("4", CH_POINT, "5", "6", 13);
        frame_bytes[12] = (frame_bytes[12] == "0") ? "1" : "0";
        send_frame();
        for (int i = 0; i < 5; i++)
        begin
            build_frame("4", CH_POINT, "5", "6", 13);
            frame_bytes[11 + (i % 2)] = bad_hex[i];
            send_frame();
        end
        // checksum wins over a missing point
        build_frame("4", ",", "5", "6", 13);
        frame_bytes[11] = 8'h67;
        send_frame();
    endtask

    task automatic test_no_point();
        build_frame("7", ",", "0", "1", 13);
        send_frame();
        // missing point wins over a blank digit
        build_frame(CH_SPACE, 8'h00, "0", "1", 13);
        send_frame();
    endtask

    task automatic test_blank_digits();
        build_frame(CH_SPACE, CH_POINT, "3", "4", 13);
        send_frame();
        build_frame("2", CH_POINT, CH_SPACE, "4", 13);
        send_frame();
        build_frame("2", CH_POINT, "3", CH_SPACE, 13);
        send_frame();
    endtask

    task automatic test_wrapping_digits();
        build_frame(8'h00, CH_POINT, 8'h00, 8'h00, 13);
        send_frame();
        build_frame(8'hFF, CH_POINT, 8'hFF, 8'hFF, 13);
        send_frame();
    endtask

    task automatic test_random_frames();
        int kind;
        int len;
        int slot;

        while (bytes_sent < 1050)
        begin
            src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
            snk_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 17;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : 13;
            kind = $urandom_range(0, 99);
            build_frame(rand_digit(), CH_POINT, rand_digit(), rand_digit(), len);
            if (kind >= 55 && kind < 65)
            begin
                slot = 11 + $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                    frame_bytes[slot] = frame_bytes[slot] ^ (8'd1 << $urandom_range(0, 7));
                else
                    frame_bytes[slot] = 8'($urandom_range(0, 255));
            end
            else if (kind >= 65 && kind < 72)
                build_frame(rand_digit(), 8'($urandom_range(0, 255)), rand_digit(),
                            rand_digit(), len);
            else if (kind >= 72 && kind < 80)
            begin
                slot = $urandom_range(0, 2);
                build_frame((slot == 0) ? CH_SPACE : rand_digit(), CH_POINT,
                            (slot == 1) ? CH_SPACE : rand_digit(),
                            (slot == 2) ? CH_SPACE : rand_digit(), len);
            end
            else if (kind >= 80 && kind < 88)
                build_frame(rand_digit(), CH_POINT, rand_digit(), rand_digit(),
                            $urandom_range(1, 12));
            else if (kind >= 88 && kind < 94)
                build_frame(8'($urandom_range(0, 255)), CH_POINT, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), len);
            else if (kind >= 94)
            begin
                len = $urandom_range(1, 20);
                frame_bytes.delete();
                for (int i = 0; i < len; i++)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.rx_byte = '0;
        byte_ch.frame_end = 1'b0;
        clear_frame();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_short_frames();
        test_good_frames();
        test_checksum_errors();
        test_no_point();
        test_blank_digits();
        test_wrapping_digits();
        test_random_frames();

        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: the slowest run ends well before this timeout
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
